// ----- rtl/pqpp_pkg.sv -----
// ============================================================================
// pqpp_pkg
// Shared types and constants for the push/pop priority queue: payload
// structs, the per-cell command and the status and opcode codes.
// ============================================================================
package pqpp_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // opcode field
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status field
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [KEY_WIDTH-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] popped_key;
        logic [KEY_WIDTH-1:0] top_key;
        logic                 is_empty;
        logic [CNT_W-1:0]     occupancy;
        logic [1:0]           status;
    } t_out_item;

    // Contents of one storage cell
    typedef struct packed {
        logic                 valid;
        logic [KEY_WIDTH-1:0] key;
    } t_slot;

    // Broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic                 max_first;
        logic [KEY_WIDTH-1:0] key;
    } t_cell_cmd;

    localparam t_slot SLOT_EMPTY = '{valid: 1'b0, key: '0};

endpackage

// ----- rtl/pqpp_cell.sv -----
// ============================================================================
// pqpp_cell
// One storage cell of the sorted chain. Keys sit in ascending order; the
// served end (front) is cell 0 in min-first mode and the last cell in
// max-first mode. A push inserts in place, a shift moves one step toward
// the front.
// ============================================================================
module pqpp_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pqpp_pkg::t_cell_cmd i_cmd,
    input  pqpp_pkg::t_slot     i_lo_slot,
    input  logic                i_lo_stay,
    input  pqpp_pkg::t_slot     i_hi_slot,
    input  logic                i_hi_stay,
    output pqpp_pkg::t_slot     o_slot,
    output logic                o_stay
);
    import pqpp_pkg::*;

    logic                 r_valid;
    logic [KEY_WIDTH-1:0] r_key;
    t_slot                n_slot;
    t_slot                w_front_slot;
    t_slot                w_back_slot;
    logic                 w_front_stay;

    // cell keeps its key on a push when it ranks at or before the new key
    assign o_stay = r_valid && (i_cmd.max_first ? (r_key >= i_cmd.key)
                                                : (r_key <= i_cmd.key));
    assign o_slot = '{valid: r_valid, key: r_key};

    // neighbor toward the front and away from it
    assign w_front_slot = i_cmd.max_first ? i_hi_slot : i_lo_slot;
    assign w_front_stay = i_cmd.max_first ? i_hi_stay : i_lo_stay;
    assign w_back_slot  = i_cmd.max_first ? i_lo_slot : i_hi_slot;

    always_comb begin
        n_slot = o_slot;
        case (i_cmd.op)
            CELL_PUSH: begin
                if (!o_stay) begin
                    if (w_front_stay) begin
                        n_slot = '{valid: 1'b1, key: i_cmd.key};
                    end else begin
                        n_slot = w_front_slot;
                    end
                end
            end
            CELL_SHIFT: begin
                n_slot = w_back_slot;
            end
            default: begin
                n_slot = o_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_slot.key;
    end

endmodule

// ----- rtl/pqpp_chain.sv -----
// ============================================================================
// pqpp_chain
// The row of storage cells with neighbor wiring. Both end cells are
// exposed; the control picks the front one by the current order.
// ============================================================================
module pqpp_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pqpp_pkg::t_cell_cmd i_cmd,
    output pqpp_pkg::t_slot     o_low_end,
    output pqpp_pkg::t_slot     o_high_end
);
    import pqpp_pkg::*;

    t_slot w_slot [CAPACITY];
    logic  w_stay [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_slot w_lo_slot;
            t_slot w_hi_slot;
            logic  w_lo_stay;
            logic  w_hi_stay;

            // past either end sits an empty slot that always ranks first
            if (g == 0) begin : g_lo_edge
                assign w_lo_slot = SLOT_EMPTY;
                assign w_lo_stay = 1'b1;
            end else begin : g_lo_link
                assign w_lo_slot = w_slot[g-1];
                assign w_lo_stay = w_stay[g-1];
            end

            if (g == CAPACITY - 1) begin : g_hi_edge
                assign w_hi_slot = SLOT_EMPTY;
                assign w_hi_stay = 1'b1;
            end else begin : g_hi_link
                assign w_hi_slot = w_slot[g+1];
                assign w_hi_stay = w_stay[g+1];
            end

            pqpp_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (i_cmd),
                .i_lo_slot (w_lo_slot),
                .i_lo_stay (w_lo_stay),
                .i_hi_slot (w_hi_slot),
                .i_hi_stay (w_hi_stay),
                .o_slot    (w_slot[g]),
                .o_stay    (w_stay[g])
            );
        end
    endgenerate

    assign o_low_end  = w_slot[0];
    assign o_high_end = w_slot[CAPACITY-1];

endmodule

// ----- rtl/priority_queue_push_pop.sv -----
// ============================================================================
// priority_queue_push_pop
// Bounded priority queue built as a sorted chain of storage cells.
// ============================================================================
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data): one push or pop per
//   transfer. Output channel (o_out_valid/i_out_ready, o_out_data): exactly
//   one result per input item, in order. Config channel (i_cfg_valid/
//   o_cfg_ready, i_cfg_max_first) selects min-first (0) or max-first (1).
//   The input transfer updates the cells and moves the control to ST_RESP;
//   from ST_RESP the output register loads from the updated front cell and
//   o_out_valid rises, once no stalled result still holds the register.
//   o_in_ready is low in ST_RESP, so a new item is taken only after the
//   result of the last one has been loaded into the output register.
//   The held keys stay packed against the served end of the chain. After
//   the order is changed with keys held, the chain slides one cell per
//   cycle toward the new end, with o_in_ready low.
//   Reset clears all cell valid bits, the count and the order (min-first).
//   When the receiver stalls, the result waits in the output register; one
//   more item may be taken, and its result waits until the register frees.
// ============================================================================
module priority_queue_push_pop (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pqpp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pqpp_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_max_first
);
    import pqpp_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_max_first;
    logic [KEY_WIDTH-1:0] r_popped;
    logic [1:0]           r_status;
    logic                 r_out_valid;
    t_out_item            r_out;

    t_cell_cmd            w_cmd;
    t_slot                w_low_end;
    t_slot                w_high_end;
    t_slot                w_front;
    logic                 w_aligned;
    logic                 w_in_xfer;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_do_push;
    logic                 w_do_pop;
    logic                 w_out_free;

    assign w_front   = r_max_first ? w_high_end : w_low_end;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    // keys held but the front cell is vacant: chain still sliding
    assign w_aligned = w_empty || w_front.valid;

    assign o_in_ready  = (r_state == ST_IDLE) && w_aligned;
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_do_push   = w_in_xfer && (i_in_data.opcode == OP_PUSH) && !w_full;
    assign w_do_pop    = w_in_xfer && (i_in_data.opcode == OP_POP) && !w_empty;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // command broadcast to the cells
    always_comb begin
        w_cmd.max_first = r_max_first;
        w_cmd.key       = i_in_data.key;
        if (w_do_push) begin
            w_cmd.op = CELL_PUSH;
        end else if (w_do_pop || !w_aligned) begin
            w_cmd.op = CELL_SHIFT;
        end else begin
            w_cmd.op = CELL_HOLD;
        end
    end

    pqpp_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_low_end  (w_low_end),
        .o_high_end (w_high_end)
    );

    // control state, count, order and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_max_first <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_first <= i_cfg_max_first;
            end
            if (w_do_push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= ST_RESP;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_RESP: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // per-item payload captured at the input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_popped <= w_do_pop ? w_front.key : '0;
            if (i_in_data.opcode == OP_POP) begin
                r_status <= w_empty ? STATUS_EMPTY : STATUS_OK;
            end else begin
                r_status <= w_full ? STATUS_FULL : STATUS_OK;
            end
        end
    end

    // result built from the updated front cell
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && w_out_free) begin
            r_out.popped_key <= r_popped;
            r_out.top_key    <= w_empty ? '0 : w_front.key;
            r_out.is_empty   <= w_empty;
            r_out.occupancy  <= r_count;
            r_out.status     <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not raise the count");

    a_front_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) && !w_empty |-> w_front.valid)
        else $error("front cell vacant while keys are held");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty |-> o_out_data.top_key == '0)
        else $error("empty result carries a top key");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_RESP) && !o_in_ready)
        else $error("new item taken before the result was formed");
`endif

endmodule

// ----- verif/priority_queue_push_pop_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// priority_queue_push_pop_tb
// Self-checking bench for the push/pop priority queue. A directed table
// covers empty pops, extreme and tied keys and an order change with keys
// held. Random phases follow, each opening with an order write once every
// result is back, then a drain past empty. Results are checked against a
// behavioral model or typed rows. Both channels see random gaps and stalls.
// ============================================================================
module priority_queue_push_pop_tb;
    import pqpp_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int SETTLE_CYC  = 4;   // block latency plus margin
    localparam int MAX_REPORTS = 10;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_in_item  item;
        logic      cfg_value;
        bit        typed;
        t_out_item result;
    } t_row;

    // DUT ports
    logic      i_clk           = 1'b0;
    logic      i_rst_n         = 1'b0;
    logic      i_in_valid      = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data       = '0;
    logic      o_out_valid;
    logic      i_out_ready     = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_valid     = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_max_first = 1'b0;

    // Model state
    logic [KEY_WIDTH-1:0] held_keys[$];
    logic                 serve_max = 1'b0;
    t_out_item            pending_results[$];

    // Bookkeeping
    int  error_count  = 0;
    int  report_count = 0;
    bit  calm         = 1'b0;   // no gaps, no stalls
    int  n_push = 0, n_pop = 0, n_empty_pop = 0, n_full_push = 0;
    int  n_cfg = 0, n_checked = 0;
    t_row plan[$];

    priority_queue_push_pop DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_first (i_cfg_max_first)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------
    // Index of the key served next under the current order, -1 if none
    function automatic int best_slot();
        int best;
        best = -1;
        foreach (held_keys[i]) begin
            if (best < 0) begin
                best = i;
            end else if (serve_max ? (held_keys[i] > held_keys[best])
                                   : (held_keys[i] < held_keys[best])) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_out_item apply_op(t_in_item it);
        t_out_item res;
        int        slot;
        res = '0;
        res.status = STATUS_OK;
        if (it.opcode == OP_PUSH) begin
            if (held_keys.size() >= CAPACITY) begin
                res.status = STATUS_FULL;
                n_full_push++;
            end else begin
                held_keys.push_back(it.key);
                n_push++;
            end
        end else begin
            slot = best_slot();
            if (slot < 0) begin
                res.status = STATUS_EMPTY;
                n_empty_pop++;
            end else begin
                res.popped_key = held_keys[slot];
                held_keys.delete(slot);
                n_pop++;
            end
        end
        slot = best_slot();
        res.top_key   = (slot >= 0) ? held_keys[slot] : '0;
        res.is_empty  = (held_keys.size() == 0);
        res.occupancy = CNT_W'(held_keys.size());
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random shaping
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return KEY_WIDTH'($urandom_range(0, 7));   // dense ties
        if (r < 40) begin
            case ($urandom_range(0, 5))
                0: return '0;
                1: return '1;
                2: return KEY_WIDTH'(1);
                3: return {{(KEY_WIDTH-1){1'b1}}, 1'b0};
                4: return {1'b1, {(KEY_WIDTH-1){1'b0}}};
                default: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
            endcase
        end
        return KEY_WIDTH'($urandom());
    endfunction

    function automatic t_in_item mk_item(logic op, logic [KEY_WIDTH-1:0] key);
        t_in_item it;
        it.opcode = op;
        it.key    = key;
        return it;
    endfunction

    function automatic t_out_item mk_result(logic [KEY_WIDTH-1:0] popped,
                                            logic [KEY_WIDTH-1:0] top,
                                            logic empty, int occ,
                                            logic [1:0] status);
        t_out_item r;
        r.popped_key = popped;
        r.top_key    = top;
        r.is_empty   = empty;
        r.occupancy  = CNT_W'(occ);
        r.status     = status;
        return r;
    endfunction

    function automatic t_row row_item(logic op, logic [KEY_WIDTH-1:0] key);
        t_row r;
        r.kind = ROW_ITEM;
        r.item = mk_item(op, key);
        r.cfg_value = 1'b0;
        r.typed = 1'b0;
        r.result = '0;
        return r;
    endfunction

    function automatic t_row row_typed(logic op, logic [KEY_WIDTH-1:0] key,
                                       t_out_item res);
        t_row r;
        r = row_item(op, key);
        r.typed  = 1'b1;
        r.result = res;
        return r;
    endfunction

    function automatic t_row row_cfg(logic value);
        t_row r;
        r = row_item(OP_PUSH, '0);
        r.kind = ROW_CFG;
        r.cfg_value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One transfer on the input channel; the expectation is queued at the
    // accepting edge. A typed result overrides the model's output.
    task automatic send_item(t_in_item it, bit typed, t_out_item typed_res);
        int        gap;
        t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = apply_op(it);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Hold the sender off until every result is back, then let it settle
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_order(logic value);
        wait_all_results();
        i_cfg_max_first <= value;
        i_cfg_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        serve_max = value;
        n_cfg++;
    endtask

    task automatic random_ops(int count, int push_pct);
        logic op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            send_item(mk_item(op, pick_key()), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and the result check
    // ------------------------------------------------------------------
    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            error_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("[%0t] unexpected result: popped=%h top=%h empty=%b occ=%0d st=%0d",
                         $realtime, got.popped_key, got.top_key, got.is_empty,
                         got.occupancy, got.status);
            end
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        if (got.popped_key !== want.popped_key || got.top_key !== want.top_key ||
            got.is_empty !== want.is_empty || got.occupancy !== want.occupancy ||
            got.status !== want.status) begin
            error_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("[%0t] result %0d mismatch", $realtime, n_checked);
                $display("    expected popped=%h top=%h empty=%b occ=%0d st=%0d",
                         want.popped_key, want.top_key, want.is_empty,
                         want.occupancy, want.status);
                $display("    actual   popped=%h top=%h empty=%b occ=%0d st=%0d",
                         got.popped_key, got.top_key, got.is_empty,
                         got.occupancy, got.status);
            end
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_data);
            // next ready value
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (calm) begin
                stall_left = 0;
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                end else begin
                    if (r < 88)      stall_left = $urandom_range(0, 2);
                    else if (r < 97) stall_left = $urandom_range(3, 6);
                    else             stall_left = $urandom_range(10, 30);
                    i_out_ready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int wait_cyc;
        logic [1:0] phase_order[6];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        plan.push_back(row_typed(OP_POP, '1, mk_result('0, '0, 1'b1, 0, STATUS_EMPTY)));
        plan.push_back(row_typed(OP_PUSH, '0, mk_result('0, '0, 1'b0, 1, STATUS_OK)));
        plan.push_back(row_item(OP_PUSH, '1));
        plan.push_back(row_item(OP_PUSH, 32'h8000_0000));
        plan.push_back(row_item(OP_PUSH, 32'h0000_0001));
        plan.push_back(row_item(OP_PUSH, '0));               // tie at the top
        plan.push_back(row_item(OP_POP, 32'h1234_5678));
        plan.push_back(row_item(OP_POP, '0));
        plan.push_back(row_cfg(1'b1));                       // order flip, keys held
        plan.push_back(row_item(OP_POP, '0));
        plan.push_back(row_item(OP_PUSH, '1));
        plan.push_back(row_item(OP_PUSH, '1));               // tie at the top
        plan.push_back(row_item(OP_POP, '0));
        plan.push_back(row_item(OP_POP, '0));
        plan.push_back(row_item(OP_POP, '0));
        plan.push_back(row_item(OP_POP, '0));
        plan.push_back(row_typed(OP_POP, '0, mk_result('0, '0, 1'b1, 0, STATUS_EMPTY)));
        plan.push_back(row_item(OP_PUSH, 32'h5555_5555));
        plan.push_back(row_item(OP_PUSH, 32'hAAAA_AAAA));
        plan.push_back(row_cfg(1'b0));
        plan.push_back(row_item(OP_POP, '1));
        plan.push_back(row_item(OP_POP, '1));
        plan.push_back(row_typed(OP_POP, '1, mk_result('0, '0, 1'b1, 0, STATUS_EMPTY)));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) write_order(plan[i].cfg_value);
            else send_item(plan[i].item, plan[i].typed, plan[i].result);
        end

        // Random phases; each opens with an order write once every result is back
        phase_order = '{2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0};
        for (int p = 0; p < 6; p++) begin
            calm = (p == 3);
            write_order(phase_order[p][0]);
            random_ops(50, (p % 2 == 0) ? 70 : 45);
            if (p == 2) wait_all_results();   // sender waits for every result
            random_ops(60, (p % 2 == 0) ? 55 : 35);
        end
        calm = 1'b0;

        // Drain past empty
        while (held_keys.size() != 0) send_item(mk_item(OP_POP, pick_key()), 1'b0, '0);
        for (int n = 0; n < 3; n++) send_item(mk_item(OP_POP, pick_key()), 1'b0, '0);

        // Drain with a bound
        i_in_valid <= 1'b0;
        wait_cyc = 0;
        while (pending_results.size() != 0 && wait_cyc < 20000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            error_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Covered %0d pushes, %0d pops, %0d pops on empty, %0d dropped pushes",
                 n_push, n_pop, n_empty_pop, n_full_push);
        $display("%0d order writes, %0d results checked, %0d mismatches",
                 n_cfg, n_checked, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pqpp_pkg.sv
rtl/pqpp_cell.sv
rtl/pqpp_chain.sv
rtl/priority_queue_push_pop.sv
verif/priority_queue_push_pop_tb.sv
